/* hdl/cbc_pkg.sv */
// ----------------------------------------------------------------------------
// cbc_pkg
// Shared widths, register indexes and stage bundles for the meshlet
// normal-cone backface cull pipeline.
// ----------------------------------------------------------------------------
package cbc_pkg;

  localparam int NUM_STG   = 6;   // register stages from input to result
  localparam int POS_W     = 32;  // Q16.16 positions
  localparam int AX_W      = 16;  // Q1.14 axis and cutoff
  localparam int D_W       = POS_W + 1;       // apex - view
  localparam int PROD_W    = D_W + AX_W;      // d * axis
  localparam int P_W       = PROD_W + 2;      // dot product
  localparam int PMAG_W    = P_W - 1;         // |p|
  localparam int PH_W      = PMAG_W / 2;      // half of |p|
  localparam int SQ_W      = 2 * D_W - 1;     // |d_i|^2
  localparam int S_W       = SQ_W + 1;        // |d|^2
  localparam int C2_W      = 2 * AX_W - 1;    // c^2
  localparam int SCH_W     = S_W / 3;         // S is split in three chunks
  localparam int M_W       = C2_W + SCH_W;    // c^2 * chunk
  localparam int WIDE_W    = 2 * PMAG_W;      // compare width
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_VIEW_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_Z = 2'd2;

  typedef struct packed {
    logic [NUM_STG-1:0] en;
    logic [NUM_STG-1:0] vld;
  } ctl_t;

  // Products of the front end.
  typedef struct packed {
    logic signed [PROD_W-1:0] prod_x;
    logic signed [PROD_W-1:0] prod_y;
    logic signed [PROD_W-1:0] prod_z;
    logic [SQ_W-1:0]          sq_x;
    logic [SQ_W-1:0]          sq_y;
    logic [SQ_W-1:0]          sq_z;
    logic [C2_W-1:0]          c2;
    logic                     c_neg;
    logic                     c_pos;
  } front_t;

  // Partial products of p^2 and c^2 * S.
  typedef struct packed {
    logic [2*PH_W-1:0] pp_hh;
    logic [2*PH_W-1:0] pp_hl;
    logic [2*PH_W-1:0] pp_ll;
    logic [M_W-1:0]    rs_m2;
    logic [M_W-1:0]    rs_m1;
    logic [M_W-1:0]    rs_m0;
    logic              s_zero;
    logic              p_neg;
    logic              c_neg;
    logic              c_pos;
  } part_t;

endpackage

/* hdl/cbc_ctrl.sv */
// ----------------------------------------------------------------------------
// cbc_ctrl
// Valid bits and per-stage load enables; a stage loads when it is empty or
// when the stage after it moves, so bubbles collapse under a stall.
// ----------------------------------------------------------------------------
module cbc_ctrl import cbc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output ctl_t ctl
);

  logic [NUM_STG-1:0] vld_r;
  logic [NUM_STG-1:0] vld_nxt;
  logic [NUM_STG-1:0] en;

  always_comb begin
    en[NUM_STG-1] = !vld_r[NUM_STG-1] || out_ready;
    for (int k = NUM_STG - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
    vld_nxt[0] = en[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NUM_STG; k++) begin
      vld_nxt[k] = en[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[NUM_STG-1];
  assign ctl.en    = en;
  assign ctl.vld   = vld_r;

endmodule

/* hdl/cbc_front.sv */
// ----------------------------------------------------------------------------
// cbc_front
// Stage 1 forms d = apex - view; stage 2 forms d*axis, |d_i|^2 and c^2.
// ----------------------------------------------------------------------------
module cbc_front import cbc_pkg::*; (
  input  logic                   clk,
  input  ctl_t                   ctl,
  input  logic signed [POS_W-1:0] apex_x,
  input  logic signed [POS_W-1:0] apex_y,
  input  logic signed [POS_W-1:0] apex_z,
  input  logic signed [AX_W-1:0]  axis_x,
  input  logic signed [AX_W-1:0]  axis_y,
  input  logic signed [AX_W-1:0]  axis_z,
  input  logic signed [AX_W-1:0]  cone_limit,
  input  logic signed [POS_W-1:0] view_x,
  input  logic signed [POS_W-1:0] view_y,
  input  logic signed [POS_W-1:0] view_z,
  output front_t                 front
);

  logic signed [D_W-1:0]  dx_r, dy_r, dz_r;
  logic signed [AX_W-1:0] ax_r, ay_r, az_r, c_r;
  logic [D_W-1:0]         mx, my, mz;
  logic [AX_W-1:0]        mc;
  front_t                 front_r;
  front_t                 front_nxt;

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      dx_r <= {apex_x[POS_W-1], apex_x} - {view_x[POS_W-1], view_x};
      dy_r <= {apex_y[POS_W-1], apex_y} - {view_y[POS_W-1], view_y};
      dz_r <= {apex_z[POS_W-1], apex_z} - {view_z[POS_W-1], view_z};
      ax_r <= axis_x;
      ay_r <= axis_y;
      az_r <= axis_z;
      c_r  <= cone_limit;
    end
  end

  // The negation wraps to the right unsigned magnitude for the most
  // negative value.
  assign mx = dx_r[D_W-1] ? D_W'(-dx_r) : D_W'(dx_r);
  assign my = dy_r[D_W-1] ? D_W'(-dy_r) : D_W'(dy_r);
  assign mz = dz_r[D_W-1] ? D_W'(-dz_r) : D_W'(dz_r);
  assign mc = c_r[AX_W-1] ? AX_W'(-c_r) : AX_W'(c_r);

  always_comb begin
    front_nxt.prod_x = {{AX_W{dx_r[D_W-1]}}, dx_r} * {{D_W{ax_r[AX_W-1]}}, ax_r};
    front_nxt.prod_y = {{AX_W{dy_r[D_W-1]}}, dy_r} * {{D_W{ay_r[AX_W-1]}}, ay_r};
    front_nxt.prod_z = {{AX_W{dz_r[D_W-1]}}, dz_r} * {{D_W{az_r[AX_W-1]}}, az_r};
    front_nxt.sq_x   = SQ_W'({{(D_W-1){1'b0}}, mx} * {{(D_W-1){1'b0}}, mx});
    front_nxt.sq_y   = SQ_W'({{(D_W-1){1'b0}}, my} * {{(D_W-1){1'b0}}, my});
    front_nxt.sq_z   = SQ_W'({{(D_W-1){1'b0}}, mz} * {{(D_W-1){1'b0}}, mz});
    front_nxt.c2     = C2_W'({{AX_W{1'b0}}, mc} * {{AX_W{1'b0}}, mc});
    front_nxt.c_neg  = c_r[AX_W-1];
    front_nxt.c_pos  = !c_r[AX_W-1] && (c_r != '0);
  end

  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      front_r <= front_nxt;
    end
  end

  assign front = front_r;

endmodule

/* hdl/cbc_reduce.sv */
// ----------------------------------------------------------------------------
// cbc_reduce
// Stage 3 sums p = dot(d, axis) and S = |d|^2; stage 4 splits |p| and S
// into narrow pieces and forms the partial products of p^2 and c^2 * S.
// ----------------------------------------------------------------------------
module cbc_reduce import cbc_pkg::*; (
  input  logic   clk,
  input  ctl_t   ctl,
  input  front_t front,
  output part_t  part
);

  logic signed [P_W-1:0] p_r;
  logic [S_W-1:0]        s_r;
  logic [C2_W-1:0]       c2_r;
  logic                  c_neg_r, c_pos_r;
  logic [PMAG_W-1:0]     p_abs;
  logic [PH_W-1:0]       ph, pl;
  part_t                 part_r;
  part_t                 part_nxt;

  always_ff @(posedge clk) begin
    if (ctl.en[2]) begin
      p_r <= {{2{front.prod_x[PROD_W-1]}}, front.prod_x}
           + {{2{front.prod_y[PROD_W-1]}}, front.prod_y}
           + {{2{front.prod_z[PROD_W-1]}}, front.prod_z};
      s_r <= {1'b0, front.sq_x} + {1'b0, front.sq_y} + {1'b0, front.sq_z};
      c2_r    <= front.c2;
      c_neg_r <= front.c_neg;
      c_pos_r <= front.c_pos;
    end
  end

  assign p_abs = p_r[P_W-1] ? PMAG_W'(-p_r) : PMAG_W'(p_r);
  assign ph    = p_abs[PMAG_W-1:PH_W];
  assign pl    = p_abs[PH_W-1:0];

  always_comb begin
    part_nxt.pp_hh  = {{PH_W{1'b0}}, ph} * {{PH_W{1'b0}}, ph};
    part_nxt.pp_hl  = {{PH_W{1'b0}}, ph} * {{PH_W{1'b0}}, pl};
    part_nxt.pp_ll  = {{PH_W{1'b0}}, pl} * {{PH_W{1'b0}}, pl};
    part_nxt.rs_m2  = {{SCH_W{1'b0}}, c2_r} * {{C2_W{1'b0}}, s_r[3*SCH_W-1:2*SCH_W]};
    part_nxt.rs_m1  = {{SCH_W{1'b0}}, c2_r} * {{C2_W{1'b0}}, s_r[2*SCH_W-1:SCH_W]};
    part_nxt.rs_m0  = {{SCH_W{1'b0}}, c2_r} * {{C2_W{1'b0}}, s_r[SCH_W-1:0]};
    part_nxt.s_zero = (s_r == '0);
    part_nxt.p_neg  = p_r[P_W-1];
    part_nxt.c_neg  = c_neg_r;
    part_nxt.c_pos  = c_pos_r;
  end

  always_ff @(posedge clk) begin
    if (ctl.en[3]) begin
      part_r <= part_nxt;
    end
  end

  assign part = part_r;

endmodule

/* hdl/cbc_decide.sv */
// ----------------------------------------------------------------------------
// cbc_decide
// Stage 5 assembles p^2 and c^2 * S from their pieces; stage 6 compares them
// by sign and magnitude and holds the cull flag for the output.
// ----------------------------------------------------------------------------
module cbc_decide import cbc_pkg::*; (
  input  logic  clk,
  input  ctl_t  ctl,
  input  part_t part,
  output logic  culled
);

  logic [WIDE_W-1:0] pp_r, rhs_r;
  logic              s_zero_r, p_neg_r, c_neg_r, c_pos_r;
  logic              culled_r;
  logic              culled_nxt;

  always_ff @(posedge clk) begin
    if (ctl.en[4]) begin
      pp_r  <= {part.pp_hh, {(2*PH_W){1'b0}}}
             + {{(PH_W-1){1'b0}}, part.pp_hl, {(PH_W+1){1'b0}}}
             + {{(2*PH_W){1'b0}}, part.pp_ll};
      rhs_r <= {{(WIDE_W-M_W-2*SCH_W){1'b0}}, part.rs_m2, {(2*SCH_W){1'b0}}}
             + {{(WIDE_W-M_W-SCH_W){1'b0}}, part.rs_m1, {SCH_W{1'b0}}}
             + {{(WIDE_W-M_W){1'b0}}, part.rs_m0};
      s_zero_r <= part.s_zero;
      p_neg_r  <= part.p_neg;
      c_neg_r  <= part.c_neg;
      c_pos_r  <= part.c_pos;
    end
  end

  // p < c*sqrt(S): signs settle most cases, squares settle the rest; with S = 0 the flag is set when c is positive.
  always_comb begin
    priority if (s_zero_r) begin
      culled_nxt = c_pos_r;
    end else if (!c_neg_r) begin
      culled_nxt = p_neg_r || (pp_r < rhs_r);
    end else begin
      culled_nxt = p_neg_r && (rhs_r < pp_r);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[5]) begin
      culled_r <= culled_nxt;
    end
  end

  assign culled = culled_r;

endmodule

/* hdl/meshlet_cone_backface_cull_core.sv */
// ----------------------------------------------------------------------------
// meshlet_cone_backface_cull_core
// Normal-cone backface test of one meshlet per beat against a configured
// camera position, exact through squared comparison.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle through a six-stage pipeline; the multipliers
// sit in stages 2 and 4, and empty stages fill in under an output stall.
// in_ready drops only when all six stages hold a beat and out_ready is low.
// Reset: synchronous, clears the stage valid bits and the view registers to
// zero; no clearing pass is needed.
module meshlet_cone_backface_cull_core import cbc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [POS_W-1:0] in_apex_x,
  input  logic signed [POS_W-1:0] in_apex_y,
  input  logic signed [POS_W-1:0] in_apex_z,
  input  logic signed [AX_W-1:0]  in_axis_x,
  input  logic signed [AX_W-1:0]  in_axis_y,
  input  logic signed [AX_W-1:0]  in_axis_z,
  input  logic signed [AX_W-1:0]  in_cone_limit,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_culled,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_addr,
  input  logic [POS_W-1:0]       cfg_wdata
);

  logic signed [POS_W-1:0] view_x_r, view_y_r, view_z_r;
  ctl_t                    ctl;
  front_t                  front;
  part_t                   part;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_x_r <= '0;
      view_y_r <= '0;
      view_z_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_VIEW_X: view_x_r <= cfg_wdata;
        REG_VIEW_Y: view_y_r <= cfg_wdata;
        REG_VIEW_Z: view_z_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  cbc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl)
  );

  cbc_front u_front (
    .clk        (clk),
    .ctl        (ctl),
    .apex_x     (in_apex_x),
    .apex_y     (in_apex_y),
    .apex_z     (in_apex_z),
    .axis_x     (in_axis_x),
    .axis_y     (in_axis_y),
    .axis_z     (in_axis_z),
    .cone_limit (in_cone_limit),
    .view_x     (view_x_r),
    .view_y     (view_y_r),
    .view_z     (view_z_r),
    .front      (front)
  );

  cbc_reduce u_reduce (
    .clk   (clk),
    .ctl   (ctl),
    .front (front),
    .part  (part)
  );

  cbc_decide u_decide (
    .clk    (clk),
    .ctl    (ctl),
    .part   (part),
    .culled (out_culled)
  );

  // Input is refused only when every stage holds a beat.
  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&ctl.vld))
    else $error("input refused while the pipeline has an empty stage");

  // A held assembly stage (stage 5) keeps its beat until it can move on.
  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.vld[NUM_STG-2] && !ctl.en[NUM_STG-2]) |=> ctl.vld[NUM_STG-2])
    else $error("stalled beat dropped from the assembly stage");

  // An accepted beat always lands in the first stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> ctl.vld[0])
    else $error("accepted beat missing from the first stage");

endmodule
